// ----- hw/rtl/hht_pkg.sv -----
// ----------------------------------------------------------------------------
// hht_pkg: shared types and constants of the hopscotch hash table
// Request codes, register map, controller states, datapath operations and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hht_pkg;

	localparam int NUM_BUCKETS_DEF = 1024;
	localparam int NBHD_SIZE_DEF   = 32;
	localparam int KEY_BITS_DEF    = 64;

	localparam int FUNC_W  = 2;
	localparam int KEY_W   = 64;
	localparam int HASH_W  = 64;
	localparam int VAL_W   = 64;
	localparam int SLOT_W  = 10;
	localparam int TS_W    = 11;
	localparam int OFF_W   = 6;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;

	localparam logic [TS_W-1:0] TS_RESET = 11'd1024;

	localparam logic [FUNC_W-1:0] FN_EXISTS = 2'd0;
	localparam logic [FUNC_W-1:0] FN_GET    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PUT    = 2'd2;

	localparam logic [PADDR_W-3:0] REG_TABLE_SIZE = 1'b0;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_BM_RD,
		ST_BM_LATCH,
		ST_LK_RD,
		ST_LK_CHK,
		ST_HIT_WR,
		ST_DECIDE,
		ST_FULL,
		ST_PR_INIT,
		ST_PR_RD,
		ST_PR_CHK,
		ST_CH_DRY,
		ST_CH_APPLY,
		ST_CH_STEP,
		ST_CH_RD,
		ST_CH_CHK,
		ST_MV_HOLE,
		ST_MV_J,
		ST_MV_BM,
		ST_INS_WR,
		ST_INS_BM,
		ST_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_CLR,
		OP_LOAD,
		OP_DIV,
		OP_BM_RD,
		OP_BM_LATCH,
		OP_LK_RD,
		OP_LK_CHK,
		OP_HIT_WR,
		OP_SET_FULL,
		OP_PR_INIT,
		OP_PR_RD,
		OP_PR_CHK,
		OP_CH_START,
		OP_CH_STEP,
		OP_CH_RD,
		OP_CH_CHK,
		OP_MV_HOLE,
		OP_MV_J,
		OP_MV_BM,
		OP_INS_WR,
		OP_INS_BM,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t  op;
		logic apply;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic lk_hit;
		logic lk_last;
		logic put;
		logic ins_req;
		logic room;
		logic pr_free;
		logic pr_last;
		logic near;
		logic j_home;
		logic ch_ok;
		logic pass;
		logic out_free;
	} stat_t;

endpackage

// ----- hw/rtl/hopscotch_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// hopscotch_hash_table_unit: hopscotch hash table with a fixed bucket store
// Exists, get and put requests on a hash table kept in on-chip memories.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result transaction. The
// hash is reduced modulo the table size by restoring division, one
// restoring step per cycle; the neighbourhood is then searched position by
// position, and on an insert buckets are probed and the move chain is walked
// in a dry pass and then in an applied pass that moves the entries, all paced
// by the single-port bucket memory. After reset a clearing pass over all
// NUM_BUCKETS buckets runs before the first request is taken. A new request
// is taken while a finished result still waits in the output register. The
// table size register should be written only while the block is idle.
module hopscotch_hash_table_unit #(
	parameter int NUM_BUCKETS = hht_pkg::NUM_BUCKETS_DEF,
	parameter int NBHD_SIZE   = hht_pkg::NBHD_SIZE_DEF,
	parameter int KEY_BITS    = hht_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hht_pkg::PADDR_W-1:0] paddr,
	input  logic [hht_pkg::DATA_W-1:0]  pwdata,
	output logic [hht_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [hht_pkg::FUNC_W-1:0]  func,
	input  logic [hht_pkg::KEY_W-1:0]   key,
	input  logic [hht_pkg::HASH_W-1:0]  hash_value,
	input  logic [hht_pkg::VAL_W-1:0]   new_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic                        inserted,
	output logic                        full_res,
	output logic [hht_pkg::VAL_W-1:0]   stored_value,
	output logic [hht_pkg::SLOT_W-1:0]  slot
);
	import hht_pkg::*;

	logic [TS_W-1:0] table_size_q;
	logic            reg_sel;
	cmd_t            cmd;
	stat_t           stat;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			table_size_q <= pwdata[TS_W-1:0];
		end
	end

	assign prdata = reg_sel ? DATA_W'(table_size_q) : '0;

	hht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	hht_dp #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.NBHD_SIZE   (NBHD_SIZE),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.table_size   (table_size_q),
		.func         (func),
		.key          (key),
		.hash_value   (hash_value),
		.new_value    (new_value),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.found        (found),
		.inserted     (inserted),
		.full_res     (full_res),
		.stored_value (stored_value),
		.slot         (slot)
	);

endmodule

// ----- hw/rtl/hht_ctrl.sv -----
// ----------------------------------------------------------------------------
// hht_ctrl: request sequencer
// Walks one request through hash reduction, neighbourhood lookup, probe,
// displacement chain and insertion by issuing datapath operations.
// ----------------------------------------------------------------------------
module hht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hht_pkg::stat_t stat,
	output hht_pkg::cmd_t  cmd
);
	import hht_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR:    if (stat.clr_last) state_nx = ST_IDLE;
			ST_IDLE:     if (in_valid) state_nx = ST_DIV;
			ST_DIV:      if (stat.div_last) state_nx = ST_BM_RD;
			ST_BM_RD:    state_nx = ST_BM_LATCH;
			ST_BM_LATCH: state_nx = ST_LK_RD;
			ST_LK_RD:    state_nx = ST_LK_CHK;
			ST_LK_CHK: begin
				if (stat.lk_hit) state_nx = stat.put ? ST_HIT_WR : ST_FIN;
				else if (stat.lk_last) state_nx = ST_DECIDE;
				else state_nx = ST_LK_RD;
			end
			ST_HIT_WR:   state_nx = ST_FIN;
			ST_DECIDE: begin
				if (!stat.ins_req) state_nx = ST_FIN;
				else if (!stat.room) state_nx = ST_FULL;
				else state_nx = ST_PR_INIT;
			end
			ST_FULL:     state_nx = ST_FIN;
			ST_PR_INIT:  state_nx = ST_PR_RD;
			ST_PR_RD:    state_nx = ST_PR_CHK;
			ST_PR_CHK: begin
				if (stat.pr_free) state_nx = ST_CH_DRY;
				else if (stat.pr_last) state_nx = ST_FULL;
				else state_nx = ST_PR_RD;
			end
			ST_CH_DRY:   state_nx = ST_CH_STEP;
			ST_CH_APPLY: state_nx = ST_CH_STEP;
			ST_CH_STEP: begin
				// The dry pass proves the chain; the second pass moves entries.
				if (stat.near) state_nx = stat.pass ? ST_INS_WR : ST_CH_APPLY;
				else if (stat.j_home) state_nx = ST_FULL;
				else state_nx = ST_CH_RD;
			end
			ST_CH_RD:    state_nx = ST_CH_CHK;
			ST_CH_CHK: begin
				if (stat.ch_ok && stat.pass) state_nx = ST_MV_HOLE;
				else state_nx = ST_CH_STEP;
			end
			ST_MV_HOLE:  state_nx = ST_MV_J;
			ST_MV_J:     state_nx = ST_MV_BM;
			ST_MV_BM:    state_nx = ST_CH_STEP;
			ST_INS_WR:   state_nx = ST_INS_BM;
			ST_INS_BM:   state_nx = ST_FIN;
			ST_FIN:      if (stat.out_free) state_nx = ST_IDLE;
			default:     state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd.op    = OP_IDLE;
		cmd.apply = 1'b0;
		in_stall  = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR:    cmd.op = OP_CLR;
			ST_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_IDLE;
			ST_DIV:      cmd.op = OP_DIV;
			ST_BM_RD:    cmd.op = OP_BM_RD;
			ST_BM_LATCH: cmd.op = OP_BM_LATCH;
			ST_LK_RD:    cmd.op = OP_LK_RD;
			ST_LK_CHK:   cmd.op = OP_LK_CHK;
			ST_HIT_WR:   cmd.op = OP_HIT_WR;
			ST_DECIDE:   cmd.op = OP_IDLE;
			ST_FULL:     cmd.op = OP_SET_FULL;
			ST_PR_INIT:  cmd.op = OP_PR_INIT;
			ST_PR_RD:    cmd.op = OP_PR_RD;
			ST_PR_CHK:   cmd.op = OP_PR_CHK;
			ST_CH_DRY:   cmd.op = OP_CH_START;
			ST_CH_APPLY: begin
				cmd.op    = OP_CH_START;
				cmd.apply = 1'b1;
			end
			ST_CH_STEP:  cmd.op = OP_CH_STEP;
			ST_CH_RD:    cmd.op = OP_CH_RD;
			ST_CH_CHK:   cmd.op = OP_CH_CHK;
			ST_MV_HOLE:  cmd.op = OP_MV_HOLE;
			ST_MV_J:     cmd.op = OP_MV_J;
			ST_MV_BM:    cmd.op = OP_MV_BM;
			ST_INS_WR:   cmd.op = OP_INS_WR;
			ST_INS_BM:   cmd.op = OP_INS_BM;
			ST_FIN:      cmd.op = stat.out_free ? OP_FIN : OP_IDLE;
			default:     cmd.op = OP_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/hht_dp.sv -----
// ----------------------------------------------------------------------------
// hht_dp: hash table datapath
// Bucket and bitmap memories, the serial hash reduction, index arithmetic
// modulo the table size and the result register.
// ----------------------------------------------------------------------------
module hht_dp #(
	parameter int NUM_BUCKETS = hht_pkg::NUM_BUCKETS_DEF,
	parameter int NBHD_SIZE   = hht_pkg::NBHD_SIZE_DEF,
	parameter int KEY_BITS    = hht_pkg::KEY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hht_pkg::cmd_t              cmd,
	output hht_pkg::stat_t             stat,
	input  logic [hht_pkg::TS_W-1:0]   table_size,
	input  logic [hht_pkg::FUNC_W-1:0] func,
	input  logic [hht_pkg::KEY_W-1:0]  key,
	input  logic [hht_pkg::HASH_W-1:0] hash_value,
	input  logic [hht_pkg::VAL_W-1:0]  new_value,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic                       found,
	output logic                       inserted,
	output logic                       full_res,
	output logic [hht_pkg::VAL_W-1:0]  stored_value,
	output logic [hht_pkg::SLOT_W-1:0] slot
);
	import hht_pkg::*;

	localparam int IDX_W    = $clog2(NUM_BUCKETS);
	localparam int AW       = IDX_W + 1;
	localparam int DW       = AW + 1;
	localparam int HW       = $clog2(NBHD_SIZE);
	localparam int MIN_SIZE = (NBHD_SIZE > 32) ? NBHD_SIZE : 32;
	localparam int CW       = (AW > TS_W) ? AW : TS_W;
	localparam logic [DW-1:0] HOP_V = DW'(NBHD_SIZE);

	function automatic logic [AW-1:0] inc_m(input logic [AW-1:0] a, input logic [AW-1:0] s);
		logic [AW-1:0] t;
		t = a + 1'b1;
		return (t == s) ? '0 : t;
	endfunction

	function automatic logic [AW-1:0] dec_m(input logic [AW-1:0] a, input logic [AW-1:0] s);
		return (a == '0) ? s - 1'b1 : a - 1'b1;
	endfunction

	function automatic logic [AW-1:0] sub_m(input logic [AW-1:0] a, input logic [AW-1:0] b,
			input logic [AW-1:0] s);
		return (a >= b) ? a - b : a + s - b;
	endfunction

	// Bucket store and neighbourhood bitmaps.
	logic [KEY_BITS-1:0]  key_mem  [NUM_BUCKETS];
	logic [VAL_W-1:0]     val_mem  [NUM_BUCKETS];
	logic [OFF_W-1:0]     off_mem  [NUM_BUCKETS];
	logic                 used_mem [NUM_BUCKETS];
	logic [NBHD_SIZE-1:0] bm_mem   [NUM_BUCKETS];

	logic                mem_we, mem_re;
	logic [IDX_W-1:0]    mem_addr;
	logic                wd_used;
	logic [KEY_BITS-1:0] wd_key;
	logic [VAL_W-1:0]    wd_val;
	logic [OFF_W-1:0]    wd_off;
	logic                rd_used_q;
	logic [KEY_BITS-1:0] rd_key_q;
	logic [VAL_W-1:0]    rd_val_q;
	logic [OFF_W-1:0]    rd_off_q;

	logic                 bm_we, bm_re;
	logic [IDX_W-1:0]     bm_addr;
	logic [NBHD_SIZE-1:0] bm_wd;
	logic [NBHD_SIZE-1:0] bm_rd_q;

	// Request and walk registers.
	logic [FUNC_W-1:0]    func_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [HASH_W-1:0]    hash_q;
	logic [VAL_W-1:0]     val_q;
	logic [AW-1:0]        size_q;
	logic [IDX_W-1:0]     rem_q;
	logic [AW-1:0]        cnt_q;
	logic [AW-1:0]        ecount_q;
	logic [IDX_W-1:0]     idx_q, pos_q, hole_q, j_q, h_q;
	logic [NBHD_SIZE-1:0] bits_q;
	logic [OFF_W-1:0]     pd_q, nd_q;
	logic                 pass_q;
	logic                 res_found_q, res_ins_q, res_full_q;
	logic                 out_valid_q, found_q, inserted_q, full_q;
	logic [VAL_W-1:0]     value_q;
	logic [SLOT_W-1:0]    slot_q;

	logic [CW-1:0]        ts_c, size_c;
	logic [AW-1:0]        div_r;
	logic [AW-1:0]        dist_hole, j_dec, h_w;
	logic [DW-1:0]        nd_w;
	logic                 near, lk_hit, ch_ok;
	logic [NBHD_SIZE-1:0] dmask, ndmask, pdmask;
	logic [VAL_W-1:0]     res_val;
	logic [IDX_W-1:0]     res_idx;
	logic [IDX_W+SLOT_W-1:0] slot_ext;

	always_comb begin
		ts_c = CW'(table_size);
		if (ts_c < CW'(MIN_SIZE)) size_c = CW'(MIN_SIZE);
		else if (ts_c > CW'(NUM_BUCKETS)) size_c = CW'(NUM_BUCKETS);
		else size_c = ts_c;
	end

	assign div_r     = {rem_q, hash_q[HASH_W-1]};
	assign dist_hole = sub_m({1'b0, hole_q}, {1'b0, rem_q}, size_q);
	assign near      = {1'b0, dist_hole} < HOP_V;
	assign j_dec     = dec_m({1'b0, j_q}, size_q);
	assign nd_w      = DW'(rd_off_q) + {1'b0, sub_m({1'b0, hole_q}, {1'b0, j_q}, size_q)};
	assign ch_ok     = rd_used_q && (nd_w < HOP_V);
	assign h_w       = sub_m({1'b0, hole_q}, AW'(nd_q), size_q);
	assign lk_hit    = bits_q[cnt_q[HW-1:0]] && rd_used_q && (rd_key_q == key_q);

	always_comb begin
		for (int i = 0; i < NBHD_SIZE; i++) begin
			dmask[i]  = (dist_hole == AW'(i));
			ndmask[i] = (nd_q == OFF_W'(i));
			pdmask[i] = (pd_q == OFF_W'(i));
		end
	end

	always_comb begin
		stat.clr_last = (cnt_q == AW'(NUM_BUCKETS - 1));
		stat.div_last = (cnt_q == AW'(HASH_W - 1));
		stat.lk_hit   = lk_hit;
		stat.lk_last  = (cnt_q == AW'(NBHD_SIZE - 1));
		stat.put      = (func_q == FN_PUT);
		stat.ins_req  = (func_q == FN_GET) || (func_q == FN_PUT);
		stat.room     = (ecount_q < size_q);
		stat.pr_free  = !rd_used_q;
		stat.pr_last  = (cnt_q == size_q - 1'b1);
		stat.near     = near;
		stat.j_home   = (j_dec == {1'b0, rem_q});
		stat.ch_ok    = ch_ok;
		stat.pass     = pass_q;
		stat.out_free = !out_valid_q || !out_stall;
	end

	// Memory port control.
	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = idx_q;
		wd_used  = 1'b1;
		wd_key   = rd_key_q;
		wd_val   = rd_val_q;
		wd_off   = rd_off_q;
		bm_we    = 1'b0;
		bm_re    = 1'b0;
		bm_addr  = rem_q;
		bm_wd    = '0;
		case (cmd.op)
			OP_CLR: begin
				mem_we   = 1'b1;
				mem_addr = cnt_q[IDX_W-1:0];
				wd_used  = 1'b0;
				bm_we    = 1'b1;
				bm_addr  = cnt_q[IDX_W-1:0];
			end
			OP_BM_RD: bm_re = 1'b1;
			OP_LK_RD, OP_PR_RD: mem_re = 1'b1;
			OP_CH_RD: begin
				mem_re   = 1'b1;
				mem_addr = j_q;
			end
			OP_HIT_WR: begin
				mem_we   = 1'b1;
				mem_addr = pos_q;
				wd_val   = val_q;
			end
			OP_MV_HOLE: begin
				mem_we   = 1'b1;
				mem_addr = hole_q;
				wd_off   = nd_q;
			end
			OP_MV_J: begin
				mem_we   = 1'b1;
				mem_addr = j_q;
				wd_used  = 1'b0;
				bm_re    = 1'b1;
				bm_addr  = h_q;
			end
			OP_MV_BM: begin
				bm_we   = 1'b1;
				bm_addr = h_q;
				bm_wd   = (bm_rd_q & ~pdmask) | ndmask;
			end
			OP_INS_WR: begin
				mem_we   = 1'b1;
				mem_addr = hole_q;
				wd_key   = key_q;
				wd_val   = (func_q == FN_PUT) ? val_q : '0;
				wd_off   = OFF_W'(dist_hole);
				bm_re    = 1'b1;
			end
			OP_INS_BM: begin
				bm_we = 1'b1;
				bm_wd = bm_rd_q | dmask;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_addr]  <= wd_key;
			val_mem[mem_addr]  <= wd_val;
			off_mem[mem_addr]  <= wd_off;
			used_mem[mem_addr] <= wd_used;
		end
		if (mem_re) begin
			rd_key_q  <= key_mem[mem_addr];
			rd_val_q  <= val_mem[mem_addr];
			rd_off_q  <= off_mem[mem_addr];
			rd_used_q <= used_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_addr] <= bm_wd;
		end
		if (bm_re) begin
			bm_rd_q <= bm_mem[bm_addr];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ecount_q    <= '0;
			pass_q      <= 1'b0;
			res_found_q <= 1'b0;
			res_ins_q   <= 1'b0;
			res_full_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CLR, OP_DIV: cnt_q <= cnt_q + 1'b1;
				OP_LOAD, OP_BM_RD, OP_PR_INIT: cnt_q <= '0;
				OP_LK_CHK: if (!lk_hit) cnt_q <= cnt_q + 1'b1;
				OP_PR_CHK: if (rd_used_q) cnt_q <= cnt_q + 1'b1;
				default: cnt_q <= cnt_q;
			endcase
			if (cmd.op == OP_LOAD) begin
				res_found_q <= 1'b0;
				res_ins_q   <= 1'b0;
				res_full_q  <= 1'b0;
			end
			if (cmd.op == OP_LK_CHK && lk_hit) res_found_q <= 1'b1;
			if (cmd.op == OP_SET_FULL) res_full_q <= 1'b1;
			if (cmd.op == OP_INS_WR) begin
				res_ins_q <= 1'b1;
				ecount_q  <= ecount_q + 1'b1;
			end
			if (cmd.op == OP_CH_START) pass_q <= cmd.apply;
			if (cmd.op == OP_FIN) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		res_val = '0;
		res_idx = '0;
		if (res_found_q) begin
			res_val = (func_q == FN_PUT) ? val_q : rd_val_q;
			res_idx = pos_q;
		end else if (res_ins_q) begin
			res_val = (func_q == FN_PUT) ? val_q : '0;
			res_idx = hole_q;
		end
	end

	assign slot_ext = (IDX_W + SLOT_W)'(res_idx);

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q <= func;
				key_q  <= key[KEY_BITS-1:0];
				hash_q <= hash_value;
				val_q  <= new_value;
				size_q <= AW'(size_c);
				rem_q  <= '0;
			end
			OP_DIV: begin
				// One restoring step of hash modulo size per cycle.
				rem_q  <= (div_r >= size_q) ? IDX_W'(div_r - size_q) : IDX_W'(div_r);
				hash_q <= {hash_q[HASH_W-2:0], 1'b0};
			end
			OP_BM_RD, OP_PR_INIT: idx_q <= rem_q;
			OP_BM_LATCH: bits_q <= bm_rd_q;
			OP_LK_CHK: begin
				if (lk_hit) pos_q <= idx_q;
				else idx_q <= IDX_W'(inc_m({1'b0, idx_q}, size_q));
			end
			OP_PR_CHK: begin
				if (!rd_used_q) pos_q <= idx_q;
				else idx_q <= IDX_W'(inc_m({1'b0, idx_q}, size_q));
			end
			OP_CH_START: begin
				hole_q <= pos_q;
				j_q    <= pos_q;
			end
			OP_CH_STEP: if (!near) j_q <= IDX_W'(j_dec);
			OP_CH_CHK: begin
				if (ch_ok) begin
					pd_q <= rd_off_q;
					nd_q <= OFF_W'(nd_w);
					if (!pass_q) hole_q <= j_q;
				end
			end
			OP_MV_HOLE: h_q <= IDX_W'(h_w);
			OP_MV_BM: hole_q <= j_q;
			OP_FIN: begin
				found_q    <= res_found_q;
				inserted_q <= res_ins_q;
				full_q     <= res_full_q;
				value_q    <= res_val;
				slot_q     <= slot_ext[SLOT_W-1:0];
			end
			default: begin
				func_q <= func_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign inserted     = inserted_q;
	assign full_res     = full_q;
	assign stored_value = value_q;
	assign slot         = slot_q;

`ifndef SYNTHESIS
	a_res_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FIN |-> $onehot0({res_found_q, res_ins_q, res_full_q}))
		else $error("more than one result kind set");
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.op == OP_FIN))
		else $error("result shown without a finish step");
	a_ins_near: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_INS_WR |-> near)
		else $error("insertion outside the home neighbourhood");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_INS_WR |-> ecount_q < size_q)
		else $error("insertion with no room left");
`endif

endmodule

// ----- dv/hopscotch_hash_table_unit_tb.sv -----
// ----------------------------------------------------------------------------
// hopscotch_hash_table_unit_tb: self-checking bench for the hopscotch table
// Drives exists, get and put requests through several table sizes, predicts
// each result with a behavioral copy of the table and compares every field.
// ----------------------------------------------------------------------------
module hopscotch_hash_table_unit_tb;
	import hht_pkg::*;

	localparam int NB       = NUM_BUCKETS_DEF;
	localparam int HD       = NBHD_SIZE_DEF;
	localparam int MIN_SZ   = (HD > 32) ? HD : 32;
	localparam int IDLE_LIM = 100000;

	// Unassigned request code; the block treats it as a plain lookup.
	localparam logic [FUNC_W-1:0] FN_RSVD = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;
		logic [VAL_W-1:0]  val;
	} request_t;

	typedef struct packed {
		logic              found;
		logic              inserted;
		logic              full;
		logic [VAL_W-1:0]  value;
		logic [SLOT_W-1:0] slot;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [KEY_W-1:0] key = '0;
	logic [HASH_W-1:0] hash_value = '0;
	logic [VAL_W-1:0] new_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found, inserted, full_res;
	logic [VAL_W-1:0] stored_value;
	logic [SLOT_W-1:0] slot;

	hopscotch_hash_table_unit u_top (.*);

	always #5 clk = ~clk;

	// Shadow copy of the table.
	logic [KEY_W-1:0] tbl_key [NB];
	logic [VAL_W-1:0] tbl_val [NB];
	logic             tbl_used [NB];
	logic [HD-1:0]    tbl_bitmap [NB];
	logic [OFF_W-1:0] tbl_offset [NB];
	int               tbl_count;
	int               tbl_size;

	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	logic [KEY_W-1:0] known_keys[$];
	int errors = 0;
	int answers_seen = 0;
	int idle_cycles = 0;
	int n_found = 0, n_ins = 0, n_full = 0;
	bit quiet_phase = 0;
	bit hold_off = 0;

	function automatic int size_in_use();
		int s;
		s = tbl_size;
		if (s < MIN_SZ) s = MIN_SZ;
		if (s > NB) s = NB;
		return s;
	endfunction

	// Walks the move chain from the hole; moves entries only when commit is set.
	function automatic int shift_hole(int home, int s, int hole, bit commit);
		int j, pd, nd, h;
		j = hole;
		if ((hole + s - home) % s < HD) return hole;
		forever begin
			j = (j + s - 1) % s;
			if (j == home) return -1;
			if (tbl_used[j]) begin
				pd = tbl_offset[j];
				nd = pd + (hole + s - j) % s;
				if (nd < HD) begin
					if (commit) begin
						h = (hole + s - nd) % s;
						tbl_key[hole] = tbl_key[j];
						tbl_val[hole] = tbl_val[j];
						tbl_offset[hole] = OFF_W'(nd);
						tbl_used[hole] = 1'b1;
						tbl_used[j] = 1'b0;
						tbl_bitmap[h][pd] = 1'b0;
						tbl_bitmap[h][nd] = 1'b1;
					end
					hole = j;
					if ((hole + s - home) % s < HD) return hole;
				end
			end
		end
	endfunction

	function automatic answer_t predict_answer(request_t r);
		answer_t a;
		int s, home, pos, hole, d, idx;
		a = '0;
		s = size_in_use();
		home = int'(r.hash % s);
		pos = -1;
		for (d = 0; d < HD && pos < 0; d++) begin
			idx = (home + d) % s;
			if (tbl_bitmap[home][d] && tbl_used[idx] && tbl_key[idx] == r.key) pos = idx;
		end
		if (pos >= 0) begin
			if (r.func == FN_PUT) tbl_val[pos] = r.val;
			a.found = 1'b1;
			a.value = tbl_val[pos];
			a.slot = SLOT_W'(pos);
			return a;
		end
		if (r.func != FN_GET && r.func != FN_PUT) return a;
		hole = -1;
		if (tbl_count < s) begin
			pos = -1;
			for (d = 0; d < s && pos < 0; d++)
				if (!tbl_used[(home + d) % s]) pos = (home + d) % s;
			if (pos >= 0 && shift_hole(home, s, pos, 0) >= 0)
				hole = shift_hole(home, s, pos, 1);
		end
		if (hole < 0) begin
			a.full = 1'b1;
			return a;
		end
		d = (hole + s - home) % s;
		tbl_used[hole] = 1'b1;
		tbl_key[hole] = r.key;
		tbl_val[hole] = (r.func == FN_PUT) ? r.val : '0;
		tbl_offset[hole] = OFF_W'(d);
		tbl_bitmap[home][d] = 1'b1;
		tbl_count++;
		a.inserted = 1'b1;
		a.value = tbl_val[hole];
		a.slot = SLOT_W'(hole);
		return a;
	endfunction

	// Stall as seen at the last rising edge, so the driver acts on the accept.
	logic in_stall_q = 1'b1;
	always @(posedge clk) in_stall_q <= !(in_valid && !in_stall) && in_valid;

	// Driver: presents queued requests, with random gaps outside the quiet phase.
	always @(negedge clk) begin
		if (!in_valid || !in_stall_q) begin
			if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(99) >= 20)) begin
				func <= pending_reqs[0].func;
				key <= pending_reqs[0].key;
				hash_value <= pending_reqs[0].hash;
				new_value <= pending_reqs[0].val;
				expected_answers.push_back(predict_answer(pending_reqs.pop_front()));
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with a long hold-off counted here.
	int hold_count = 0;
	always @(negedge clk) begin
		if (hold_off && hold_count < 3000) begin
			hold_count <= hold_count + 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 20);
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		answer_t e;
		int bad;
		bad = 0;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIM) begin
			$display("simulation failed");
			$finish;
		end
		if (out_valid && !out_stall) begin
			answers_seen <= answers_seen + 1;
			if (expected_answers.size() == 0) begin
				$error("result with no request outstanding");
				bad++;
			end else begin
				e = expected_answers.pop_front();
				n_found <= n_found + e.found;
				n_ins <= n_ins + e.inserted;
				n_full <= n_full + e.full;
				if (found !== e.found) begin
					$error("found: expected %0d actual %0d", e.found, found);
					bad++;
				end
				if (inserted !== e.inserted) begin
					$error("inserted: expected %0d actual %0d", e.inserted, inserted);
					bad++;
				end
				if (full_res !== e.full) begin
					$error("full_res: expected %0d actual %0d", e.full, full_res);
					bad++;
				end
				if (stored_value !== e.value) begin
					$error("stored_value: expected %h actual %h", e.value, stored_value);
					bad++;
				end
				if (slot !== e.slot) begin
					$error("slot: expected %0d actual %0d", e.slot, slot);
					bad++;
				end
			end
			errors <= errors + bad;
		end
	end

	task automatic write_table_size(input int value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_TABLE_SIZE, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tbl_size = value & 11'h7ff;
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && expected_answers.size() == 0 && !in_valid);
		repeat (400) @(negedge clk);
	endtask

	function automatic request_t make_req(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] k,
			logic [HASH_W-1:0] h, logic [VAL_W-1:0] v);
		request_t r;
		r.func = fn;
		r.key = k;
		r.hash = h;
		r.val = v;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Reuses earlier keys half the time so lookups hit; hashes cluster to force moves.
	task automatic queue_random(int count, int hot);
		logic [KEY_W-1:0] k;
		logic [FUNC_W-1:0] fn;
		for (int i = 0; i < count; i++) begin
			if (known_keys.size() > 0 && $urandom_range(99) < 50)
				k = known_keys[$urandom_range(known_keys.size() - 1)];
			else begin
				k = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(4000));
				known_keys.push_back(k);
			end
			fn = ($urandom_range(99) < 8) ? FN_RSVD : FUNC_W'($urandom_range(2));
			// The hash is derived from the key; random upper bits, added now and then, can move its home.
			pending_reqs.push_back(make_req(fn, k,
				(k * 64'h9e37) % hot +
				(($urandom_range(9) == 0) ? rand64() & 64'hffff_0000 : 64'd0),
				rand64()));
		end
	endtask

	initial begin
		for (int i = 0; i < NB; i++) begin
			tbl_used[i] = 1'b0;
			tbl_bitmap[i] = '0;
			tbl_key[i] = '0;
			tbl_val[i] = '0;
			tbl_offset[i] = '0;
		end
		tbl_count = 0;
		tbl_size = TS_RESET;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, every code including the unused one.
		pending_reqs.push_back(make_req(FN_EXISTS, '1, '1, '1));
		pending_reqs.push_back(make_req(FN_PUT, '1, '1, '1));
		pending_reqs.push_back(make_req(FN_EXISTS, '1, '1, '0));
		pending_reqs.push_back(make_req(FN_GET, '0, '0, '1));
		pending_reqs.push_back(make_req(FN_PUT, '0, '0, 64'h5555_aaaa_5555_aaaa));
		pending_reqs.push_back(make_req(FN_RSVD, '0, '0, '1));
		pending_reqs.push_back(make_req(FN_RSVD, 64'hdead, 64'd17, '1));
		pending_reqs.push_back(make_req(FN_GET, 64'haaaa_5555_aaaa_5555, 64'd1023, '0));
		for (int i = 0; i < 6; i++)
			pending_reqs.push_back(make_req(FN_PUT, 64'(100 + i), 64'd1023, rand64()));
		drain();

		// Smallest size: fill until the table reports full.
		write_table_size(32);
		for (int i = 0; i < 40; i++)
			pending_reqs.push_back(make_req(FN_PUT, 64'(5000 + i), 64'(i % 3), rand64()));
		drain();

		// Out-of-range sizes are clamped by the block.
		write_table_size(5);
		queue_random(20, 40);
		drain();
		write_table_size(2047);
		queue_random(20, 2048);
		drain();

		// Long receiver hold-off while requests keep coming.
		write_table_size(64);
		hold_off = 1;
		queue_random(40, 64);
		drain();

		write_table_size(200);
		quiet_phase = 1;
		queue_random(80, 100);
		drain();
		quiet_phase = 0;
		queue_random(120, 200);
		drain();

		write_table_size(1024);
		queue_random(130, 1024);
		drain();

		$display("covered %0d results: %0d hits, %0d inserts, %0d full, sizes 32..1024",
			answers_seen, n_found, n_ins, n_full);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/hht_pkg.sv
hw/rtl/hht_ctrl.sv
hw/rtl/hht_dp.sv
hw/rtl/hopscotch_hash_table_unit.sv
dv/hopscotch_hash_table_unit_tb.sv
